FILE: rtl/core/ntp_server_reply_with_client_table_unit_assert.svh
// assertion macros for the ntp server reply unit
`ifndef NTP_SERVER_REPLY_WITH_CLIENT_TABLE_UNIT_ASSERT_SVH
`define NTP_SERVER_REPLY_WITH_CLIENT_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NTPSRV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NTPSRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ntpsrv_pkg.sv
// shared types and constants for the ntp server reply unit
`timescale 1ns / 1ps

package ntpsrv_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LIMIT_W     = 5;
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [10:0] NTP_LENGTH     = 11'd48;
  localparam logic [31:0] EPOCH_OFFSET   = 32'd2208988800;
  localparam logic [22:0] MS_TO_FRACTION = 23'd4294967;
  localparam logic [7:0]  HDR_FLAGS      = 8'h24;
  localparam logic [7:0]  HDR_STRATUM    = 8'h01;
  localparam logic [31:0] SYNC_MAX       = 32'hFFFF_FFFF;
  localparam logic [7:0]  PRECISION_RST  = 8'd0;
  localparam logic [4:0]  LIMIT_RST      = 5'd15;

  // configuration register indexes
  localparam logic REG_PRECISION    = 1'b0;
  localparam logic REG_CLIENT_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } ctl_state_t;

  // search token walking down the client chain
  typedef struct packed {
    logic              vld;
    logic [31:0]       addr;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       sync;
  } srch_tok_t;

  // insertion of a new client into one cell
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       addr;
  } cell_wr_t;

endpackage

FILE: rtl/core/ntpsrv_cell.sv
// one client table entry with its stage of the search chain
`timescale 1ns / 1ps

module ntpsrv_cell import ntpsrv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  logic [CNT_W-1:0]  count,
  input  cell_wr_t          wr,
  input  srch_tok_t         tok_in,
  output srch_tok_t         tok_out
);

  logic [31:0] addr_r;
  logic [31:0] sync_r;
  logic [31:0] sync_inc;
  srch_tok_t   tok_r;
  srch_tok_t   tok_nxt;
  logic        live;
  logic        match;

  // only entries below the fill count hold a client
  assign live     = CNT_W'(cell_idx) < count;
  assign match    = tok_in.vld && !tok_in.hit && live && (addr_r == tok_in.addr);
  assign sync_inc = (sync_r == SYNC_MAX) ? sync_r : sync_r + 32'd1;

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.slot = cell_idx;
      tok_nxt.sync = sync_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (match) begin
      sync_r <= sync_inc;
    end
    if (wr.en && (wr.slot == cell_idx)) begin
      addr_r <= wr.addr;
      sync_r <= 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: rtl/core/ntpsrv_chain.sv
// row of client cells that a search token passes through
`timescale 1ns / 1ps

module ntpsrv_chain import ntpsrv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] count,
  input  cell_wr_t         wr,
  input  srch_tok_t        tok_in,
  output srch_tok_t        tok_out
);

  srch_tok_t tok_w [0:TABLE_DEPTH];

  assign tok_w[0] = tok_in;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ntpsrv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(i)),
      .count    (count),
      .wr       (wr),
      .tok_in   (tok_w[i]),
      .tok_out  (tok_w[i+1])
    );
  end

  assign tok_out = tok_w[TABLE_DEPTH];

endmodule

FILE: rtl/core/ntp_server_reply_with_client_table_unit.sv
// ntp stratum-1 reply builder with client address table
// reply path: launch register, the row of client cells, done register, reply register
// a new request is taken only once the reply for the last one is registered, as the
//   search token walks the row of client cells; a dropped request leaves the unit idle
// reset: synchronous active low, clears the fill count, config and handshakes;
//   table entries are undefined until written
`timescale 1ns / 1ps

`include "ntp_server_reply_with_client_table_unit_assert.svh"

module ntp_server_reply_with_client_table_unit import ntpsrv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] in_request_length,
  input  logic [7:0]  in_request_poll,
  input  logic [63:0] in_client_transmit_stamp,
  input  logic [31:0] in_client_address,
  input  logic [31:0] in_rx_unix_seconds,
  input  logic [31:0] in_tx_unix_seconds,
  input  logic [9:0]  in_subsecond_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_header_word,
  output logic [63:0] out_reference_stamp,
  output logic [63:0] out_origin_stamp,
  output logic [63:0] out_receive_stamp,
  output logic [63:0] out_transmit_stamp,
  output logic [3:0]  out_client_slot,
  output logic [31:0] out_client_sync_count,
  output logic        out_client_added,
  output logic        out_table_full
);

  ctl_state_t       state_r, state_nxt;
  logic [7:0]       precision_r;
  logic [4:0]       limit_r;
  logic [CNT_W-1:0] count_r;

  logic [7:0]       poll_r;
  logic [63:0]      origin_r;
  logic [31:0]      rx_secs_r;
  logic [31:0]      tx_secs_r;
  logic [31:0]      frac_r;
  logic [32:0]      frac_prod;

  srch_tok_t        launch_r;
  srch_tok_t        tok_end;
  srch_tok_t        done_r;
  cell_wr_t         ins_wr;

  logic             in_acc;
  logic             len_ok;
  logic             out_free;
  logic             room;
  logic             finish;
  logic             out_valid_r;
  logic [SLOT_W+3:0] slot_ext;

  assign in_acc   = in_valid && in_ready;
  assign len_ok   = in_request_length == NTP_LENGTH;
  assign out_free = !out_valid_r || out_ready;
  assign room     = (CMP_W'(count_r) < CMP_W'(TABLE_DEPTH)) &&
                    (CMP_W'(count_r) < CMP_W'(limit_r));
  assign frac_prod = 33'(in_subsecond_ms) * 33'(MS_TO_FRACTION);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r <= PRECISION_RST;
      limit_r     <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PRECISION:    precision_r <= cfg_wdata;
        REG_CLIENT_LIMIT: limit_r     <= cfg_wdata[4:0];
        default:          ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      poll_r    <= in_request_poll;
      origin_r  <= in_client_transmit_stamp;
      rx_secs_r <= in_rx_unix_seconds + EPOCH_OFFSET;
      tx_secs_r <= in_tx_unix_seconds + EPOCH_OFFSET;
      frac_r    <= frac_prod[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= '0;
    end else begin
      launch_r.vld  <= in_acc && len_ok;
      launch_r.addr <= in_client_address;
      launch_r.hit  <= 1'b0;
      launch_r.slot <= '0;
      launch_r.sync <= '0;
    end
  end

  ntpsrv_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .count   (count_r),
    .wr      (ins_wr),
    .tok_in  (launch_r),
    .tok_out (tok_end)
  );

  always_ff @(posedge clk) begin
    if (tok_end.vld) begin
      done_r <= tok_end;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc && len_ok) state_nxt = ST_SEARCH;
      ST_SEARCH: if (tok_end.vld) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    finish   = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SEARCH: ;
      ST_DONE:   finish = out_free;
      default:   ;
    endcase
  end

  always_comb begin
    ins_wr.en   = finish && !done_r.hit && room;
    ins_wr.slot = count_r[SLOT_W-1:0];
    ins_wr.addr = done_r.addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ins_wr.en) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // reply register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    slot_ext = '0;
    if (done_r.hit) begin
      slot_ext = (SLOT_W + 4)'(done_r.slot);
    end else if (room) begin
      slot_ext = (SLOT_W + 4)'(count_r[SLOT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_header_word       <= {HDR_FLAGS, HDR_STRATUM, poll_r, precision_r};
      out_reference_stamp   <= {rx_secs_r, 32'd0};
      out_origin_stamp      <= origin_r;
      out_receive_stamp     <= {rx_secs_r, frac_r};
      out_transmit_stamp    <= {tx_secs_r, frac_r};
      out_client_slot       <= slot_ext[3:0];
      out_client_sync_count <= done_r.hit ? done_r.sync : (room ? 32'd1 : 32'd0);
      out_client_added      <= !done_r.hit && room;
      out_table_full        <= !done_r.hit && !room;
    end
  end

  assign out_valid = out_valid_r;

  `NTPSRV_ASSERT_NOW(a_tok_in_search, tok_end.vld, state_r == ST_SEARCH,
    "search token left the chain outside a search")
  `NTPSRV_ASSERT_NEXT(a_count_step, ins_wr.en,
    count_r == $past(count_r) + CNT_W'(1), "fill count did not advance on insert")
  `NTPSRV_ASSERT_NOW(a_hit_sync, tok_end.vld && tok_end.hit, tok_end.sync != 32'd0,
    "known client returned a zero sync count")

endmodule
